// ===== design/hte_pkg.sv =====
package hte_pkg;

    localparam logic [15:0] CAP_MIN   = 16'd7;
    localparam logic [15:0] CAP_RESET = 16'd4096;

    typedef enum logic [2:0] {
        KIND_PLAIN,
        KIND_AMP,
        KIND_LT,
        KIND_GT,
        KIND_QUOT,
        KIND_APOS,
        KIND_TERM
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
    } t_cmd;

    function automatic t_kind classify(input logic [7:0] ch);
        t_kind k;
        case (ch)
            8'h00:   k = KIND_TERM;
            "&":     k = KIND_AMP;
            "<":     k = KIND_LT;
            ">":     k = KIND_GT;
            8'h22:   k = KIND_QUOT;
            8'h27:   k = KIND_APOS;
            default: k = KIND_PLAIN;
        endcase
        return k;
    endfunction

    // Number of output bytes a word of this kind produces.
    function automatic logic [2:0] kind_len(input t_kind k);
        logic [2:0] n;
        case (k)
            KIND_AMP:  n = 3'd5;
            KIND_LT:   n = 3'd4;
            KIND_GT:   n = 3'd4;
            KIND_QUOT: n = 3'd6;
            KIND_APOS: n = 3'd6;
            default:   n = 3'd1;
        endcase
        return n;
    endfunction

    // Entity text, first character in the top byte.
    function automatic logic [47:0] kind_text(input t_kind k);
        logic [47:0] t;
        case (k)
            KIND_AMP:  t = {"&amp;", 8'h00};
            KIND_LT:   t = {"&lt;", 16'h0000};
            KIND_GT:   t = {"&gt;", 16'h0000};
            KIND_QUOT: t = "&quot;";
            KIND_APOS: t = "&#x27;";
            default:   t = 48'h0;
        endcase
        return t;
    endfunction

endpackage

// ===== design/hte_ifs.sv =====
interface hte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    modport source(output valid, output char_in, input ready);
    modport sink(input valid, input char_in, output ready);
endinterface

interface hte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
    modport source(output valid, output out_byte, output run_last, output string_end,
                   input ready);
    modport sink(input valid, input out_byte, input run_last, input string_end,
                 output ready);
endinterface

interface hte_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_capacity;
    modport source(output valid, output out_capacity, input ready);
    modport sink(input valid, input out_capacity, output ready);
endinterface

// ===== design/hte_front.sv =====
module hte_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hte_in_if.sink        i_in,
    hte_cfg_if.sink       i_cfg,
    output logic          o_push_valid,
    output hte_pkg::t_cmd o_push_cmd,
    input  logic          i_push_ready
);

    logic [15:0]    r_cap;
    logic [15:0]    r_count;
    logic           r_trunc;
    logic [15:0]    n_count;
    logic           n_trunc;
    hte_pkg::t_kind w_kind;
    logic [2:0]     w_len;
    logic           w_fits;
    logic           w_acc;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = i_push_ready;
    assign w_acc       = i_in.valid && i_in.ready;

    assign w_kind = hte_pkg::classify(i_in.char_in);
    assign w_len  = hte_pkg::kind_len(w_kind);
    // One place must always stay free for the terminator.
    assign w_fits = ({1'b0, r_count} + {14'd0, w_len}) < {1'b0, r_cap};

    assign o_push_cmd.kind = w_kind;
    assign o_push_cmd.ch   = i_in.char_in;

    always_comb begin
        n_count      = r_count;
        n_trunc      = r_trunc;
        o_push_valid = 1'b0;
        if (w_acc) begin
            if (w_kind == hte_pkg::KIND_TERM) begin
                n_count      = 16'd0;
                n_trunc      = 1'b0;
                o_push_valid = 1'b1;
            end else if (!r_trunc) begin
                if (w_fits) begin
                    n_count      = r_count + {13'd0, w_len};
                    o_push_valid = 1'b1;
                end else begin
                    n_trunc = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= hte_pkg::CAP_RESET;
            r_count <= 16'd0;
            r_trunc <= 1'b0;
        end else begin
            r_count <= n_count;
            r_trunc <= n_trunc;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= (i_cfg.out_capacity < hte_pkg::CAP_MIN) ?
                         hte_pkg::CAP_MIN : i_cfg.out_capacity;
            end
        end
    end

endmodule

// ===== design/hte_queue.sv =====
module hte_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    input  hte_pkg::t_cmd i_push_cmd,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output hte_pkg::t_cmd o_pop_cmd,
    input  logic          i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    hte_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_push_ready = (r_cnt != CW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== design/hte_back.sv =====
module hte_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  hte_pkg::t_cmd i_cmd,
    output logic          o_pop,
    hte_out_if.source     o_out
);

    logic [2:0]  r_idx;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last;
    logic        r_end;
    logic [2:0]  w_len;
    logic [47:0] w_text;
    logic [7:0]  w_byte;
    logic        w_last;
    logic        w_fire;

    assign w_len  = hte_pkg::kind_len(i_cmd.kind);
    assign w_text = hte_pkg::kind_text(i_cmd.kind);
    assign w_last = (r_idx == w_len - 3'd1);

    always_comb begin
        case (i_cmd.kind)
            hte_pkg::KIND_PLAIN: w_byte = i_cmd.ch;
            hte_pkg::KIND_TERM:  w_byte = 8'h00;
            default:             w_byte = w_text[8 * (5 - int'(r_idx)) +: 8];
        endcase
    end

    // The output register is refilled in the cycle it is taken.
    assign w_fire = i_cmd_valid && (!r_valid || o_out.ready);
    assign o_pop  = w_fire && w_last;

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.run_last   = r_last;
    assign o_out.string_end = r_end;

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_byte <= w_byte;
            r_last <= w_last;
            r_end  <= (i_cmd.kind == hte_pkg::KIND_TERM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            if (w_fire) begin
                r_valid <= 1'b1;
                r_idx   <= w_last ? 3'd0 : r_idx + 3'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== design/html_escape_truncating.sv =====
// An item's words reach the output through the command queue and then the output register.
// Throughput: one output word per cycle unless the queue is empty or o_out.ready stalls.
// Each item yields one word (plain byte or terminator), four to six (entity) or none (dropped).
// Input words are taken every cycle while the command queue between front and back has room.
// Reset (synchronous, active low) empties the queue and output register, clears the count
// and the truncation flag, and sets the capacity to 4096.
module html_escape_truncating #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hte_in_if.sink    i_in,
    hte_cfg_if.sink   i_cfg,
    hte_out_if.source o_out
);

    logic          w_push_valid;
    hte_pkg::t_cmd w_push_cmd;
    logic          w_push_ready;
    logic          w_cmd_valid;
    hte_pkg::t_cmd w_cmd;
    logic          w_pop;

    hte_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (i_cfg),
        .o_push_valid (w_push_valid),
        .o_push_cmd   (w_push_cmd),
        .i_push_ready (w_push_ready)
    );

    hte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .i_push_cmd   (w_push_cmd),
        .o_push_ready (w_push_ready),
        .o_pop_valid  (w_cmd_valid),
        .o_pop_cmd    (w_cmd),
        .i_pop        (w_pop)
    );

    hte_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

endmodule
